// ===== src/owdp_pkg.sv =====
// ----------------------------------------------------------------------------
// owdp_pkg
// Shared widths, constants and codes for the omni wheel drive packetizer.
// ----------------------------------------------------------------------------
package owdp_pkg;

    localparam int VEL_W      = 16;
    localparam int ADDR_W     = 8;
    localparam int CMD_W      = 3;
    localparam int VAL_W      = 7;
    localparam int LIM_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int FRAC_BITS_DEF = 8;

    // trig constants carry 16 fraction bits
    localparam int K_FRAC     = 16;
    localparam int HALF_SHIFT = K_FRAC - 1;

    // internal datapath widths
    localparam int T_W        = 34;   // weighted velocity sum
    localparam int S_W        = 42;   // wheel command, signed
    localparam int M_W        = 40;   // wheel magnitude
    localparam int R_W        = 48;   // divider numerator / remainder
    localparam int LANES      = 3;
    localparam int Q_W        = 7;    // drive byte quotient
    localparam int PRE_STAGES = 6;

    localparam logic signed [16:0] K_SIN60 = 17'sd56755;
    localparam logic signed [16:0] K_ROT   = 17'sd19661;

    // gain 257 = 2^8 + 1
    localparam int GAIN_SHIFT = 8;

    localparam int DRIVE_STOP = 64;
    localparam int STOP_SHIFT = 6;

    localparam logic [CMD_W-1:0]  CMD_CH1 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_CH2 = 3'd7;

    localparam logic [ADDR_W-1:0] ADDR1_RST = 8'd128;
    localparam logic [ADDR_W-1:0] ADDR2_RST = 8'd129;
    localparam logic [LIM_W-1:0]  LIMIT_RST = 6'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_ADDR  = 2'd0,
        REG_SECOND_ADDR = 2'd1,
        REG_DRIVE_LIMIT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PKT_WHEEL1 = 2'd0,
        PKT_WHEEL3 = 2'd1,
        PKT_WHEEL2 = 2'd2
    } t_pkt_slot;

endpackage

// ===== src/omni_wheel_drive_packetizer.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_drive_packetizer
// Three-wheel omni inverse kinematics with proportional limiting, emitting
// three controller packets per velocity command.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | i_in_valid / o_in_stall | vel_x, vel_y, yaw_rate
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | register index, data
//   out     | source    | o_out_valid/i_out_stall | address, command, value, sum
//
// A command enters a 13-stage pipeline (6 arithmetic stages, 7 divider
// steps, one bit each); its packets are then loaded into the serializer.
// The single output channel sends one packet per cycle while i_out_stall
// is low, three per command; the input takes one per cycle until the
// pipeline backs up. Output stall freezes it once the last stage is full.
// Reset clears valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module omni_wheel_drive_packetizer #(
    parameter int FRAC_BITS = owdp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [owdp_pkg::VEL_W-1:0] i_vel_x,
    input  logic signed [owdp_pkg::VEL_W-1:0] i_vel_y,
    input  logic signed [owdp_pkg::VEL_W-1:0] i_yaw_rate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [owdp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [owdp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [owdp_pkg::ADDR_W-1:0]       o_packet_address,
    output logic [owdp_pkg::CMD_W-1:0]        o_packet_command,
    output logic [owdp_pkg::VAL_W-1:0]        o_drive_value,
    output logic [owdp_pkg::VAL_W-1:0]        o_packet_checksum,
    output logic                              o_last_packet
);
    import owdp_pkg::*;

    localparam int SHIFT     = K_FRAC + FRAC_BITS;
    localparam int DIV_STEPS = Q_W;
    localparam int NSTG      = PRE_STAGES + DIV_STEPS;

    // config registers
    logic [ADDR_W-1:0] r_addr1;
    logic [ADDR_W-1:0] r_addr2;
    logic [LIM_W-1:0]  r_limit;

    // pipeline valid bits
    logic [NSTG-1:0] r_v;

    // flow control
    logic w_take;
    logic w_ser_free;
    logic w_adv;
    logic w_load;

    // stage 1
    logic signed [T_W-1:0] r1_px, r1_hy, r1_fy, r1_rot;
    logic signed [T_W-1:0] n1_px, n1_hy, n1_fy, n1_rot;
    // stage 2
    logic signed [T_W-1:0] r2_t [LANES];
    logic signed [T_W-1:0] n2_t [LANES];
    // stage 3
    logic signed [S_W-1:0] r3_s [LANES];
    logic signed [S_W-1:0] n3_s [LANES];
    // stage 4
    logic signed [S_W-1:0] r4_s [LANES];
    logic [M_W-1:0]        r4_m [LANES];
    logic [M_W-1:0]        n4_m [LANES];
    // stage 5
    logic signed [S_W-1:0] r5_s [LANES];
    logic [M_W-1:0]        r5_mx;
    logic [M_W-1:0]        n5_mx;
    // stage 6
    logic [M_W-1:0]        w_lim;
    logic signed [S_W-1:0] w_one;
    logic                  r6_sc,  n6_sc;
    logic [M_W-1:0]        r6_mx;
    logic [R_W-1:0]        r6_num [LANES];
    logic [R_W-1:0]        n6_num [LANES];
    logic [VAL_W-1:0]      r6_u   [LANES];
    logic [VAL_W-1:0]      n6_u   [LANES];
    // divider steps
    logic [R_W-1:0]        r_drem [DIV_STEPS][LANES];
    logic [R_W-1:0]        n_drem [DIV_STEPS][LANES];
    logic [Q_W-1:0]        r_dq   [DIV_STEPS][LANES];
    logic [Q_W-1:0]        n_dq   [DIV_STEPS][LANES];
    logic [VAL_W-1:0]      r_du   [DIV_STEPS][LANES];
    logic [M_W-1:0]        r_dmx  [DIV_STEPS];
    logic                  r_dsc  [DIV_STEPS];
    logic [VAL_W-1:0]      w_fin  [LANES];

    // output serializer
    logic              r_busy, n_busy;
    t_pkt_slot         r_slot, n_slot;
    logic [VAL_W-1:0]  r_val [LANES];

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr1 <= ADDR1_RST;
            r_addr2 <= ADDR2_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FIRST_ADDR:  r_addr1 <= i_cfg_data;
                REG_SECOND_ADDR: r_addr2 <= i_cfg_data;
                REG_DRIVE_LIMIT: r_limit <= LIM_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign w_take     = r_busy && !i_out_stall;
    assign w_ser_free = !r_busy || (w_take && (r_slot == PKT_WHEEL2));
    assign w_adv      = !r_v[NSTG-1] || w_ser_free;
    assign w_load     = r_v[NSTG-1] && w_ser_free;
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NSTG-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // arithmetic stages
    // ------------------------------------------------------------------
    always_comb begin
        n1_px  = T_W'(K_SIN60 * i_vel_x);
        n1_hy  = T_W'(i_vel_y) <<< HALF_SHIFT;
        n1_fy  = T_W'(i_vel_y) <<< K_FRAC;
        n1_rot = T_W'(K_ROT * i_yaw_rate);
    end

    always_comb begin
        n2_t[0] = r1_hy + r1_rot - r1_px;
        n2_t[1] = r1_rot - r1_fy;
        n2_t[2] = r1_px + r1_hy + r1_rot;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n3_s[l] = (S_W'(r2_t[l]) <<< GAIN_SHIFT) + S_W'(r2_t[l]);
            n4_m[l] = r3_s[l][S_W-1] ? M_W'(-r3_s[l]) : M_W'(r3_s[l]);
        end
    end

    always_comb begin
        n5_mx = r4_m[0];
        if (r4_m[1] > n5_mx) begin
            n5_mx = r4_m[1];
        end
        if (r4_m[2] > n5_mx) begin
            n5_mx = r4_m[2];
        end
    end

    assign w_lim = M_W'(r_limit) << SHIFT;
    assign w_one = S_W'(DRIVE_STOP) <<< SHIFT;

    always_comb begin
        n6_sc = r5_mx > w_lim;
        for (int l = 0; l < LANES; l++) begin
            // 64*mx - s*limit, positive whenever scaling applies
            n6_num[l] = R_W'($signed(R_W'(r5_mx) << STOP_SHIFT)
                        - R_W'(r5_s[l]) * $signed({1'b0, r_limit}));
            n6_u[l]   = VAL_W'((w_one - r5_s[l]) >>> SHIFT);
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    always_comb begin
        logic [R_W-1:0] w_src;
        logic [R_W-1:0] w_dvs;
        logic [Q_W-1:0] w_q;
        logic [M_W-1:0] w_mx;
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int l = 0; l < LANES; l++) begin
                if (j == 0) begin
                    w_src = r6_num[l];
                    w_q   = '0;
                    w_mx  = r6_mx;
                end else begin
                    w_src = r_drem[j-1][l];
                    w_q   = r_dq[j-1][l];
                    w_mx  = r_dmx[j-1];
                end
                w_dvs = R_W'(w_mx) << (DIV_STEPS - 1 - j);
                if (w_src >= w_dvs) begin
                    n_drem[j][l] = w_src - w_dvs;
                    n_dq[j][l]   = w_q | (Q_W'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    n_drem[j][l] = w_src;
                    n_dq[j][l]   = w_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_px  <= n1_px;
            r1_hy  <= n1_hy;
            r1_fy  <= n1_fy;
            r1_rot <= n1_rot;
            for (int l = 0; l < LANES; l++) begin
                r2_t[l]   <= n2_t[l];
                r3_s[l]   <= n3_s[l];
                r4_s[l]   <= r3_s[l];
                r4_m[l]   <= n4_m[l];
                r5_s[l]   <= r4_s[l];
                r6_num[l] <= n6_num[l];
                r6_u[l]   <= n6_u[l];
            end
            r5_mx <= n5_mx;
            r6_sc <= n6_sc;
            r6_mx <= r5_mx;
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_drem[j][l] <= n_drem[j][l];
                    r_dq[j][l]   <= n_dq[j][l];
                    r_du[j][l]   <= (j == 0) ? r6_u[l] : r_du[j-1][l];
                end
                r_dmx[j] <= (j == 0) ? r6_mx : r_dmx[j-1];
                r_dsc[j] <= (j == 0) ? r6_sc : r_dsc[j-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_fin[l] = r_dsc[DIV_STEPS-1] ? r_dq[DIV_STEPS-1][l] : r_du[DIV_STEPS-1][l];
        end
    end

    // ------------------------------------------------------------------
    // output serializer: packet order wheel one, wheel three, wheel two
    // ------------------------------------------------------------------
    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        if (w_load) begin
            n_busy = 1'b1;
            n_slot = PKT_WHEEL1;
        end else if (w_take) begin
            unique case (r_slot)
                PKT_WHEEL1: n_slot = PKT_WHEEL3;
                PKT_WHEEL3: n_slot = PKT_WHEEL2;
                PKT_WHEEL2: n_busy = 1'b0;
                default:    n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= PKT_WHEEL1;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_val[0] <= w_fin[0];
            r_val[1] <= w_fin[2];
            r_val[2] <= w_fin[1];
        end
    end

    always_comb begin
        unique case (r_slot)
            PKT_WHEEL1: begin
                o_packet_address = r_addr1;
                o_packet_command = CMD_CH1;
                o_drive_value    = r_val[0];
                o_last_packet    = 1'b0;
            end
            PKT_WHEEL3: begin
                o_packet_address = r_addr1;
                o_packet_command = CMD_CH2;
                o_drive_value    = r_val[1];
                o_last_packet    = 1'b0;
            end
            PKT_WHEEL2: begin
                o_packet_address = r_addr2;
                o_packet_command = CMD_CH1;
                o_drive_value    = r_val[2];
                o_last_packet    = 1'b1;
            end
            default: begin
                o_packet_address = r_addr1;
                o_packet_command = CMD_CH1;
                o_drive_value    = r_val[0];
                o_last_packet    = 1'b0;
            end
        endcase
    end

    assign o_packet_checksum = VAL_W'(o_packet_address + ADDR_W'(o_packet_command)
                                      + ADDR_W'(o_drive_value));
    assign o_out_valid       = r_busy;

endmodule
